>>> design/lpcf_pkg.sv
// ----------------------------------------------------------------------------
// lpcf_pkg
// Shared types and constants of the local peak clip filter: field widths,
// register reset values, register indexes and action codes.
// ----------------------------------------------------------------------------
package lpcf_pkg;

  // default sizing of the line stores and the pixel word
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned CFG_W_BITS = 11;
  localparam int unsigned CFG_H_BITS = 13;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = 13'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eor;
    logic             eof;
  } res_t;

endpackage

>>> design/lpcf_pix_if.sv
// ----------------------------------------------------------------------------
// lpcf_pix_if
// Input channel: one raster pixel or one flush tick per item.
// ----------------------------------------------------------------------------
interface lpcf_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [lpcf_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

>>> design/lpcf_res_if.sv
// ----------------------------------------------------------------------------
// lpcf_res_if
// Output channel: one filtered pixel with row and frame end flags per item.
// ----------------------------------------------------------------------------
interface lpcf_res_if;
  logic                        valid;
  logic                        ready;
  logic [lpcf_pkg::PIX_W-1:0]  pixel_out;
  logic                        end_of_row;
  logic                        end_of_frame;

  modport source (output valid, output pixel_out, output end_of_row, output end_of_frame,
                  input ready);
  modport sink   (input valid, input pixel_out, input end_of_row, input end_of_frame,
                  output ready);
endinterface

>>> design/local_peak_clip_filter.sv
// ----------------------------------------------------------------------------
// local_peak_clip_filter
// Four-neighbour local maximum clipping on a raster pixel stream.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps that rate for as long as the
// result side takes its items: every pixel reads the two line stores in the
// cycle it is accepted and writes them back at the same edge, so no item
// waits on another. A pixel comes back when the pixel one row below it goes
// in; the last row of a frame is drained with flush items, one pixel each.
// Results leave through an output register backed by one skid entry, so the
// input keeps flowing for one more item while a result waits. The line
// stores are not cleared; every entry is written before it is read.
// Writing frame_width or frame_height restarts the frame; a value of 0 counts as
// 1 and values above the store size are clipped to it.
// ----------------------------------------------------------------------------
module local_peak_clip_filter #(
  parameter int unsigned MAX_WIDTH  = lpcf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lpcf_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PIXEL_BITS = lpcf_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpcf_pkg::APB_AW-1:0]   paddr,
  input  logic [lpcf_pkg::APB_DW-1:0]   pwdata,
  output logic [lpcf_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  lpcf_pix_if.sink                      pix_i,
  lpcf_res_if.source                    res_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = RW + 1;
  localparam int unsigned SW = (PIXEL_BITS < lpcf_pkg::PIX_W) ? PIXEL_BITS : lpcf_pkg::PIX_W;

  // ---------------------------------------------------------------- config
  logic [lpcf_pkg::CFG_W_BITS-1:0] cfg_w_q;
  logic [lpcf_pkg::CFG_H_BITS-1:0] cfg_h_q;
  logic                            cfg_wr;
  logic [CW-1:0]                   eff_w;
  logic [HW-1:0]                   eff_h;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= lpcf_pkg::FRAME_WIDTH_RST;
      cfg_h_q <= lpcf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lpcf_pkg::REG_FRAME_WIDTH:  cfg_w_q <= pwdata[lpcf_pkg::CFG_W_BITS-1:0];
        lpcf_pkg::REG_FRAME_HEIGHT: cfg_h_q <= pwdata[lpcf_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lpcf_pkg::REG_FRAME_WIDTH:  prdata = lpcf_pkg::APB_DW'(cfg_w_q);
      lpcf_pkg::REG_FRAME_HEIGHT: prdata = lpcf_pkg::APB_DW'(cfg_h_q);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_h_q);
    end
  end

  // ---------------------------------------------------------------- state
  logic [AW-1:0] ic_q, ic_d;
  logic [AW-1:0] oc_q, oc_d;
  logic [RW-1:0] orow_q, orow_d;
  logic [CW-1:0] pend_q, pend_d;
  logic [SW-1:0] left_q, left_d;

  // line stores and their read ports
  logic [SW-1:0] mid_mem_q [MAX_WIDTH];
  logic [SW-1:0] up_mem_q  [MAX_WIDTH];
  logic [SW-1:0] mid_a_q, mid_b_q, up_rd_q;
  logic [SW-1:0] mid_byp_q, up_byp_q;
  logic          mid_a_hit_q, mid_b_hit_q, up_hit_q;
  logic [AW-1:0] mid_raddr_a, mid_raddr_b;
  logic          mid_we, up_we;

  // ---------------------------------------------------------------- output skid
  lpcf_pkg::res_t out_q, skid_q, res_new;
  logic           out_v_q, skid_v_q;
  logic           take;

  // ---------------------------------------------------------------- datapath
  logic          acc, is_flush, emit, has_down, last_row, last_col, pend_full;
  logic [CW-1:0] oc_inc, ic_inc;
  logic [HW-1:0] orow_inc;
  logic [SW-1:0] p, center, right_v, up_v, top, m1, m2;
  logic [SW-1:0] up_m, left_m, right_m, down_m;
  logic          up_en, left_en, right_en, down_en, peak, any_nb;
  logic [SW-1:0] res_pix;

  assign pix_i.ready = !skid_v_q;
  assign acc      = pix_i.valid && pix_i.ready;
  assign is_flush = (pix_i.action == lpcf_pkg::ACT_FLUSH);
  assign p        = pix_i.pixel_in[SW-1:0];

  assign oc_inc    = {1'b0, oc_q} + CW'(1);
  assign ic_inc    = {1'b0, ic_q} + CW'(1);
  assign orow_inc  = {1'b0, orow_q} + HW'(1);
  assign last_col  = (oc_inc >= eff_w);
  assign last_row  = (orow_inc >= eff_h);
  assign pend_full = (pend_q >= eff_w);

  // flush only drains the last row of a frame
  assign emit = acc && (is_flush ? ((pend_q != '0) && last_row) : pend_full);
  assign has_down = !is_flush && !last_row;

  // window around the output pixel, with same-edge writes forwarded
  assign center  = mid_a_hit_q ? mid_byp_q : mid_a_q;
  assign right_v = mid_b_hit_q ? mid_byp_q : mid_b_q;
  assign up_v    = up_hit_q    ? up_byp_q  : up_rd_q;

  assign up_en    = (orow_q != '0);
  assign left_en  = (oc_q != '0);
  assign right_en = (oc_inc < eff_w);
  assign down_en  = has_down;

  assign up_m    = up_en    ? up_v    : '0;
  assign left_m  = left_en  ? left_q  : '0;
  assign right_m = right_en ? right_v : '0;
  assign down_m  = down_en  ? p       : '0;

  assign peak = (!up_en || (center > up_v)) && (!left_en || (center > left_q)) &&
                (!right_en || (center > right_v)) && (!down_en || (center > p));
  assign any_nb = up_en || left_en || right_en || down_en;

  assign m1      = (up_m > left_m) ? up_m : left_m;
  assign m2      = (right_m > down_m) ? right_m : down_m;
  assign top     = (m1 > m2) ? m1 : m2;
  assign res_pix = (peak && any_nb) ? top : center;

  assign res_new.pixel = lpcf_pkg::PIX_W'(res_pix);
  assign res_new.eor   = (oc_inc == eff_w);
  assign res_new.eof   = (oc_inc == eff_w) && last_row;

  assign mid_we = acc && !is_flush && !cfg_wr;
  assign up_we  = emit && !cfg_wr;

  always_comb begin
    ic_d   = ic_q;
    oc_d   = oc_q;
    orow_d = orow_q;
    pend_d = pend_q;
    left_d = left_q;
    if (cfg_wr) begin
      ic_d   = '0;
      oc_d   = '0;
      orow_d = '0;
      pend_d = '0;
    end else if (acc) begin
      if (emit) begin
        left_d = center;
        if (last_col) begin
          oc_d   = '0;
          orow_d = last_row ? '0 : orow_inc[RW-1:0];
        end else begin
          oc_d = oc_inc[AW-1:0];
        end
      end
      if (is_flush) begin
        if (emit) begin
          pend_d = pend_q - CW'(1);
        end
      end else begin
        if (!pend_full) begin
          pend_d = pend_q + CW'(1);
        end
        ic_d = (ic_inc >= eff_w) ? '0 : ic_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      oc_q   <= '0;
      orow_q <= '0;
      pend_q <= '0;
    end else begin
      ic_q   <= ic_d;
      oc_q   <= oc_d;
      orow_q <= orow_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
  end

  // reads are addressed with the next output column and registered
  assign mid_raddr_a = oc_d;
  assign mid_raddr_b = oc_d + AW'(1);

  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem_q[ic_q] <= p;
    end
    mid_a_q <= mid_mem_q[mid_raddr_a];
    mid_b_q <= mid_mem_q[mid_raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (up_we) begin
      up_mem_q[oc_q] <= center;
    end
    up_rd_q <= up_mem_q[oc_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_a_hit_q <= 1'b0;
      mid_b_hit_q <= 1'b0;
      up_hit_q    <= 1'b0;
    end else begin
      mid_a_hit_q <= mid_we && (ic_q == mid_raddr_a);
      mid_b_hit_q <= mid_we && (ic_q == mid_raddr_b);
      up_hit_q    <= up_we && (oc_q == oc_d);
    end
  end

  always_ff @(posedge clk_i) begin
    mid_byp_q <= p;
    up_byp_q  <= center;
  end

  // ---------------------------------------------------------------- result side
  assign take = out_v_q && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || take) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= emit;
        end else begin
          out_v_q <= emit;
        end
      end else if (emit) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (emit) begin
          skid_q <= res_new;
        end
      end else if (emit) begin
        out_q <= res_new;
      end
    end else if (emit) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.pixel_out    = out_q.pixel;
  assign res_o.end_of_row   = out_q.eor;
  assign res_o.end_of_frame = out_q.eof;

endmodule
